// ===== sv/assert_macros.svh =====
// Assertion macros shared by the block averager RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, ignored while rst_n is low.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, also during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/tcba_pkg.sv =====
// Package for the two-channel block averager: widths, codes and types.
// No dependencies; imported by the interfaces and all modules.
package tcba_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int LOG2_W          = 4;
  localparam int LOG2_MAX        = 10;
  localparam int LOG2_RESET      = 6;
  // Count reaches at most 2^LOG2_MAX before the block closes.
  localparam int CNT_W           = LOG2_MAX + 1;
  localparam int FRESH_W         = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LOG2_W;

  localparam logic [CFG_IDX_W-1:0] CFG_AVG_LOG2_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_LOG2_B = 1'b1;

  localparam logic OP_CONV = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic CH_A = 1'b0;
  localparam logic CH_B = 1'b1;

  typedef enum logic [1:0] {
    STAT_NOT_READY = 2'd0,
    STAT_READY     = 2'd1,
    STAT_OVERRUN   = 2'd2
  } tcba_status_t;

  // Control from the read decode to the result register.
  typedef struct packed {
    logic         load;
    tcba_status_t status;
  } rsp_ctl_t;

endpackage

// ===== sv/tcba_in_if.sv =====
// Request channel of the block averager: valid/ready plus the request fields.
// Depends on tcba_pkg.
interface tcba_in_if
  import tcba_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [SAMPLE_BITS-1:0] sample_a;
  logic [SAMPLE_BITS-1:0] sample_b;
  logic                   channel;

  modport source (output valid, op, sample_a, sample_b, channel, input ready);
  modport sink   (input valid, op, sample_a, sample_b, channel, output ready);
endinterface

// ===== sv/tcba_out_if.sv =====
// Result channel of the block averager: valid/ready plus status and value.
// Depends on tcba_pkg.
interface tcba_out_if
  import tcba_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  tcba_status_t           status;
  logic [SAMPLE_BITS-1:0] value;

  modport source (output valid, status, value, input ready);
  modport sink   (input valid, status, value, output ready);
endinterface

// ===== sv/tcba_chan.sv =====
// One averaging channel: accumulator, sample count, latched mean and ready count.
// Depends on tcba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcba_chan
  import tcba_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [LOG2_W-1:0]      avg_log2,
  input  logic                   conv_en,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   rd_clr,
  output logic [SAMPLE_BITS-1:0] mean,
  output logic [FRESH_W-1:0]     fresh
);

  localparam int SUM_W = SAMPLE_BITS + LOG2_MAX;

  logic [SUM_W-1:0]       sum_r, sum_nxt, sum_add, sum_shr;
  logic [CNT_W-1:0]       count_r, count_nxt, count_inc, blk_size;
  logic [SAMPLE_BITS-1:0] mean_r, mean_nxt, avg_sat;
  logic [FRESH_W-1:0]     fresh_r, fresh_nxt;
  logic [LOG2_W-1:0]      n_eff;
  logic                   blk_done;

  always_comb begin
    // Register codes above the maximum behave as the maximum.
    n_eff     = (avg_log2 > LOG2_W'(LOG2_MAX)) ? LOG2_W'(LOG2_MAX) : avg_log2;
    sum_add   = sum_r + SUM_W'(sample);
    count_inc = count_r + CNT_W'(1);
    blk_size  = CNT_W'(1) << n_eff;
    blk_done  = (count_inc >= blk_size);
    sum_shr   = sum_add >> n_eff;
    // A block size lowered mid-block can leave an average above full scale.
    if (|sum_shr[SUM_W-1:SAMPLE_BITS]) begin
      avg_sat = '1;
    end else begin
      avg_sat = sum_shr[SAMPLE_BITS-1:0];
    end

    sum_nxt   = sum_r;
    count_nxt = count_r;
    mean_nxt  = mean_r;
    fresh_nxt = fresh_r;
    if (conv_en) begin
      if (blk_done) begin
        sum_nxt   = '0;
        count_nxt = '0;
        mean_nxt  = avg_sat;
        if (fresh_r < FRESH_W'(2)) begin
          fresh_nxt = fresh_r + FRESH_W'(1);
        end
      end else begin
        sum_nxt   = sum_add;
        count_nxt = count_inc;
      end
    end else if (rd_clr) begin
      fresh_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
      mean_r  <= '0;
      fresh_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      mean_r  <= mean_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  assign mean  = mean_r;
  assign fresh = fresh_r;

  `ASSERT_CLK_RST(a_fresh_sat, fresh_r != FRESH_W'(3), "ready count passed saturation")
  `ASSERT_CLK_RST(a_count_bound, count_r < (CNT_W'(1) << LOG2_MAX), "sample count out of range")
  `ASSERT_CLK_RST(a_read_clears, (rd_clr && !conv_en) |=> (fresh_r == '0), "read did not clear")

endmodule

// ===== sv/tcba_rsp.sv =====
// Result register of the block averager: holds one read response until taken.
// Depends on tcba_pkg and the tcba_out_if interface.
module tcba_rsp
  import tcba_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rsp_ctl_t               ctl,
  input  logic [SAMPLE_BITS-1:0] value,
  output logic                   can_take,
  tcba_out_if.source             out_ch
);

  logic                   valid_r, valid_nxt;
  tcba_status_t           status_r;
  logic [SAMPLE_BITS-1:0] value_r;

  // The slot frees in the same cycle its response is taken.
  assign can_take = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      status_r <= ctl.status;
      value_r  <= value;
    end
  end

  assign out_ch.valid  = valid_r;
  assign out_ch.status = status_r;
  assign out_ch.value  = value_r;

endmodule

// ===== sv/two_channel_block_averager_unit.sv =====
// Top level of the two-channel block averager: config registers, two channels,
// read decode and result register. Depends on tcba_pkg, interfaces, tcba_chan, tcba_rsp.
//
//   Port      Dir   Carries
//   in_ch     in    op, sample_a, sample_b, channel (conversion or read request)
//   out_ch    out   status, value (one response per read request)
//   cfg_*     in    avg_log2_a / avg_log2_b writes
//
// One request per cycle: the channel state updates at the accepting edge and a read
// response lands in the result register at the same edge. The result register sets
// the rate: in_ch.ready is low only while a response waits and out_ch.ready is low.
// Reset is synchronous; all counts, sums and averages clear to zero and both block
// sizes return to 64 samples.
`include "assert_macros.svh"

module two_channel_block_averager_unit
  import tcba_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tcba_in_if.sink               in_ch,
  tcba_out_if.source            out_ch
);

  logic [LOG2_W-1:0]      avg_log2_a_r, avg_log2_b_r;
  logic                   can_take, acc, conv_en, rd_en;
  logic [SAMPLE_BITS-1:0] mean_a, mean_b, rd_mean, rd_value;
  logic [FRESH_W-1:0]     fresh_a, fresh_b, rd_fresh;
  rsp_ctl_t               rsp_ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_log2_a_r <= LOG2_W'(LOG2_RESET);
      avg_log2_b_r <= LOG2_W'(LOG2_RESET);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_AVG_LOG2_A: avg_log2_a_r <= cfg_wdata;
        CFG_AVG_LOG2_B: avg_log2_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = can_take;
  assign acc         = in_ch.valid && can_take;
  assign conv_en     = acc && (in_ch.op == OP_CONV);
  assign rd_en       = acc && (in_ch.op == OP_READ);

  tcba_chan #(.SAMPLE_BITS(SAMPLE_BITS)) u_chan_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .avg_log2 (avg_log2_a_r),
    .conv_en  (conv_en),
    .sample   (in_ch.sample_a),
    .rd_clr   (rd_en && (in_ch.channel == CH_A)),
    .mean     (mean_a),
    .fresh    (fresh_a)
  );

  tcba_chan #(.SAMPLE_BITS(SAMPLE_BITS)) u_chan_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .avg_log2 (avg_log2_b_r),
    .conv_en  (conv_en),
    .sample   (in_ch.sample_b),
    .rd_clr   (rd_en && (in_ch.channel == CH_B)),
    .mean     (mean_b),
    .fresh    (fresh_b)
  );

  always_comb begin
    rd_mean  = (in_ch.channel == CH_A) ? mean_a : mean_b;
    rd_fresh = (in_ch.channel == CH_A) ? fresh_a : fresh_b;
    rsp_ctl.load = rd_en;
    rd_value     = rd_mean;
    case (rd_fresh)
      FRESH_W'(0): begin
        rsp_ctl.status = STAT_NOT_READY;
        rd_value       = '0;
      end
      FRESH_W'(1): rsp_ctl.status = STAT_READY;
      default:     rsp_ctl.status = STAT_OVERRUN;
    endcase
  end

  tcba_rsp #(.SAMPLE_BITS(SAMPLE_BITS)) u_rsp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rsp_ctl),
    .value    (rd_value),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

  `ASSERT_CLK_RST(a_read_responds, rd_en |=> out_ch.valid, "read request gave no response")

endmodule
